[rtl/core/c3s_pkg.sv]
// ----------------------------------------------------------------------------
// c3s_pkg: shared types and constants of the 3x3 RGB convolution unit
// Field widths, window geometry, kernel fixed-point format and the
// configuration register map.
// ----------------------------------------------------------------------------
package c3s_pkg;

   // pixel and kernel formats
   localparam int PIX_W          = 8;
   localparam int NUM_CHANS      = 3;
   localparam int RGB_W          = PIX_W * NUM_CHANS;
   localparam int COEF_W         = 16;
   localparam int COEF_FRAC_BITS = 8;

   // window geometry
   localparam int NUM_ROWS = 3;
   localparam int NUM_COLS = 3;
   localparam int ROW_TOP  = 0;
   localparam int ROW_MID  = 1;
   localparam int ROW_BOT  = 2;

   // accumulation widths: 8u x 16s product, three per column, three columns
   localparam int PROD_W    = PIX_W + COEF_W;
   localparam int COL_SUM_W = PROD_W + 2;
   localparam int SUM_W     = COL_SUM_W + 2;

   // configuration register widths and reset values
   localparam int CSR_DATA_W   = 48;
   localparam int CSR_INDEX_W  = 3;
   localparam int FRAME_W_W    = 12;
   localparam int FRAME_H_W    = 16;
   localparam int KROW_W       = COEF_W * NUM_COLS;
   localparam logic [FRAME_W_W-1:0] FRAME_W_RESET = 12'd640;
   localparam logic [FRAME_H_W-1:0] FRAME_H_RESET = 16'd480;
   localparam logic [KROW_W-1:0]    KROW_TOP_RESET = 48'h0000_0000_0000;
   localparam logic [KROW_W-1:0]    KROW_MID_RESET = 48'h0000_0100_0000;
   localparam logic [KROW_W-1:0]    KROW_BOT_RESET = 48'h0000_0000_0000;

   // smallest frame dimension and first position with a full window
   localparam int MIN_DIM   = 3;
   localparam int FIRST_OUT = 2;

   // result queue depth (power of two)
   localparam int RSP_DEPTH = 8;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FRAME_WIDTH  = 3'd0,
      CSR_FRAME_HEIGHT = 3'd1,
      CSR_KROW_TOP     = 3'd2,
      CSR_KROW_MID     = 3'd3,
      CSR_KROW_BOTTOM  = 3'd4
   } csr_index_type;

   // one pixel: blue in the low byte, red in the high byte
   typedef struct packed {
      logic [PIX_W-1:0] red;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] blue;
   } rgb_type;

   // line store entry: pixel two rows up and one row up at the same column
   typedef struct packed {
      rgb_type older;
      rgb_type newer;
   } line_pair_type;

   // one window column, index ROW_TOP .. ROW_BOT
   typedef logic [NUM_ROWS-1:0][RGB_W-1:0]  tap_col_type;
   // one kernel column, index ROW_TOP .. ROW_BOT
   typedef logic [NUM_ROWS-1:0][COEF_W-1:0] coef_col_type;
   // per-channel column sums, channel 0 is blue
   typedef logic [NUM_CHANS-1:0][COL_SUM_W-1:0] chan_sum_type;

   // control carried alongside the arithmetic pipeline
   typedef struct packed {
      logic valid;
      logic last;
   } pipe_ctl_type;

   // one finished result
   typedef struct packed {
      logic [PIX_W-1:0] blue;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] red;
      logic             last;
   } rsp_type;

endpackage

[rtl/core/c3s_ram.sv]
// ----------------------------------------------------------------------------
// c3s_ram: generic simple dual-port RAM
// One write port and one read port, read data registered on read enable.
// ----------------------------------------------------------------------------
module c3s_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port, hold between reads
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/c3s_tap_cell.sv]
// ----------------------------------------------------------------------------
// c3s_tap_cell: one column cell of the 3x3 window
// Holds three taps of one window column, hands them to the left neighbour
// on each shift, and forms the per-channel column sum against its kernel
// column over two registered stages.
// ----------------------------------------------------------------------------
module c3s_tap_cell import c3s_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         shift_en,
   input  tap_col_type  col_in,
   input  coef_col_type coef,
   output tap_col_type  col_out,
   output chan_sum_type sum_out
);

   function automatic logic signed [PROD_W-1:0] mul_px(input logic [PIX_W-1:0] px,
                                                      input logic [COEF_W-1:0] cf);
      logic signed [PROD_W:0] full;
      full = $signed({1'b0, px}) * $signed(cf);
      return full[PROD_W-1:0];
   endfunction

   tap_col_type             taps_ff;
   logic signed [PROD_W-1:0] prod_in [NUM_ROWS][NUM_CHANS];
   logic signed [PROD_W-1:0] prod_ff [NUM_ROWS][NUM_CHANS];
   chan_sum_type            sum_in;
   chan_sum_type            sum_ff;

   // hold taps, take the right neighbour's column on shift
   always_ff @(posedge clock) begin
      if (reset) begin
         taps_ff <= '0;
      end else if (shift_en) begin
         taps_ff <= col_in;
      end
   end

   // products of every tap and channel with its coefficient
   always_comb begin
      for (int r = 0; r < NUM_ROWS; r++) begin
         for (int ch = 0; ch < NUM_CHANS; ch++) begin
            prod_in[r][ch] = mul_px(taps_ff[r][PIX_W*ch +: PIX_W], coef[r]);
         end
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   // column sum per channel
   always_comb begin
      for (int ch = 0; ch < NUM_CHANS; ch++) begin
         sum_in[ch] = COL_SUM_W'(prod_ff[ROW_TOP][ch])
                    + COL_SUM_W'(prod_ff[ROW_MID][ch])
                    + COL_SUM_W'(prod_ff[ROW_BOT][ch]);
      end
   end

   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
   end

   assign col_out = taps_ff;
   assign sum_out = sum_ff;

endmodule

[rtl/core/c3s_rsp_fifo.sv]
// ----------------------------------------------------------------------------
// c3s_rsp_fifo: result queue with slot reservation
// Results are reserved when their pixel is taken in and written once the
// arithmetic pipeline delivers them; the input side is throttled so that a
// reserved result always finds a free entry.
// ----------------------------------------------------------------------------
module c3s_rsp_fifo import c3s_pkg::*; #(
   parameter int DEPTH = 8
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    reserve,
   input  logic    push,
   input  rsp_type push_data,
   output logic    pop_valid,
   input  logic    pop_ready,
   output rsp_type pop_data,
   output logic    slot_free
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   rsp_type            mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;
   logic [CNT_W-1:0]   occ_ff;
   logic [CNT_W-1:0]   occ_in;
   logic               pop;

   assign pop = pop_valid && pop_ready;

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   // stored entry count
   always_comb begin
      unique case ({push, pop})
         2'b10:   count_in = count_ff + CNT_W'(1);
         2'b01:   count_in = count_ff - CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   // reserved plus stored entries
   always_comb begin
      unique case ({reserve, pop})
         2'b10:   occ_in = occ_ff + CNT_W'(1);
         2'b01:   occ_in = occ_ff - CNT_W'(1);
         default: occ_in = occ_ff;
      endcase
   end

   // advance pointers and counts
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
         occ_ff    <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         end
         count_ff <= count_in;
         occ_ff   <= occ_in;
      end
   end

   assign pop_valid = (count_ff != '0);
   assign pop_data  = mem_ff[rd_ptr_ff];
   assign slot_free = (occ_ff < CNT_W'(DEPTH));

endmodule

[rtl/core/conv3x3_rgb_saturating_unit.sv]
// ----------------------------------------------------------------------------
// conv3x3_rgb_saturating_unit: streaming 3x3 convolution of an RGB frame
// Line stores, a row of three window column cells, an adder and saturation
// stage, and a result queue.
// ----------------------------------------------------------------------------
// Usage:
//   Pixels enter on req_* in raster order, one transfer per pixel. Each
//   channel is filtered with one shared 3x3 kernel of signed Q8.8
//   coefficients; the sum is floored and clamped to 0..255. A result leaves
//   on rsp_* only for interior pixels; rsp_frame_last marks the last one of
//   the frame. The result for pixel (r-1, c-1) is produced by the input
//   transfer at (r, c).
//   Throughput is one pixel per clock while req_ready is high: each pixel
//   takes one read and one write of the shared line store, on separate ports
//   in separate cycles.
//   Reset clears the counters, the window and the queue; geometry returns
//   to 640 x 480 and the kernel to identity. Line stores are not cleared.
//   When the receiver stalls, up to 8 results are held; req_ready drops once
//   all queue entries are taken or reserved by pixels still in the pipe.
//   Write the csr_* port only while no pixel is in flight; the unit does not enforce it.
// ----------------------------------------------------------------------------
module conv3x3_rgb_saturating_unit import c3s_pkg::*; #(
   parameter int MAX_WIDTH = 2048
) (
   input  logic                   clock,
   input  logic                   reset,
   // pixel input
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [PIX_W-1:0]       req_blue_in,
   input  logic [PIX_W-1:0]       req_green_in,
   input  logic [PIX_W-1:0]       req_red_in,
   // result output
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [PIX_W-1:0]       rsp_blue_out,
   output logic [PIX_W-1:0]       rsp_green_out,
   output logic [PIX_W-1:0]       rsp_red_out,
   output logic                   rsp_frame_last,
   // configuration writes
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int CW  = $clog2(MAX_WIDTH);
   localparam int WCW = ($clog2(MAX_WIDTH + 1) > FRAME_W_W) ? $clog2(MAX_WIDTH + 1)
                                                              : FRAME_W_W;

   function automatic logic [PIX_W-1:0] sat_pixel(input logic [SUM_W-1:0] s);
      logic [SUM_W-1:0] q;
      q = s >> COEF_FRAC_BITS;
      if (s[SUM_W-1]) begin
         return '0;
      end else if (|q[SUM_W-1:PIX_W]) begin
         return '1;
      end else begin
         return q[PIX_W-1:0];
      end
   endfunction

   // configuration registers
   logic [FRAME_W_W-1:0] frame_width_ff;
   logic [FRAME_H_W-1:0] frame_height_ff;
   logic [KROW_W-1:0]    krow_top_ff;
   logic [KROW_W-1:0]    krow_mid_ff;
   logic [KROW_W-1:0]    krow_bot_ff;

   // geometry
   logic [WCW-1:0]       width_ext;
   logic [WCW-1:0]       width_eff;
   logic [CW-1:0]        col_last;
   logic [FRAME_H_W-1:0] row_last;

   // position counters
   logic [CW-1:0]        col_ff;
   logic [CW-1:0]        col_in;
   logic [FRAME_H_W-1:0] row_ff;
   logic [FRAME_H_W-1:0] row_in;
   logic                 req_xfer;
   logic                 emit;
   logic                 emit_last;

   // line store stage
   logic                 s1_valid_ff;
   logic                 s1_emit_ff;
   logic                 s1_last_ff;
   logic [CW-1:0]        s1_addr_ff;
   rgb_type              s1_pix_ff;
   rgb_type              req_pix;
   line_pair_type        line_rd;
   line_pair_type        line_wr;

   // window cells
   tap_col_type          cell_col_in  [NUM_COLS];
   tap_col_type          cell_col_out [NUM_COLS];
   coef_col_type         cell_coef    [NUM_COLS];
   chan_sum_type         cell_sum     [NUM_COLS];
   tap_col_type          fresh_col;

   // arithmetic pipeline control
   pipe_ctl_type         win_ctl_ff;
   pipe_ctl_type         prod_ctl_ff;
   pipe_ctl_type         col_ctl_ff;
   pipe_ctl_type         tot_ctl_ff;
   logic [SUM_W-1:0]     tot_in [NUM_CHANS];
   logic [SUM_W-1:0]     tot_ff [NUM_CHANS];
   rsp_type              push_data;
   rsp_type              pop_data;

   // configuration writes; codes without a register are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FRAME_W_RESET;
         frame_height_ff <= FRAME_H_RESET;
         krow_top_ff     <= KROW_TOP_RESET;
         krow_mid_ff     <= KROW_MID_RESET;
         krow_bot_ff     <= KROW_BOT_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH:  frame_width_ff  <= csr_wdata[FRAME_W_W-1:0];
            CSR_FRAME_HEIGHT: frame_height_ff <= csr_wdata[FRAME_H_W-1:0];
            CSR_KROW_TOP:     krow_top_ff     <= csr_wdata[KROW_W-1:0];
            CSR_KROW_MID:     krow_mid_ff     <= csr_wdata[KROW_W-1:0];
            CSR_KROW_BOTTOM:  krow_bot_ff     <= csr_wdata[KROW_W-1:0];
            default: ;
         endcase
      end
   end

   // clamp geometry to the supported range
   always_comb begin
      width_ext = WCW'(frame_width_ff);
      priority if (width_ext < WCW'(MIN_DIM)) begin
         width_eff = WCW'(MIN_DIM);
      end else if (width_ext > WCW'(MAX_WIDTH)) begin
         width_eff = WCW'(MAX_WIDTH);
      end else begin
         width_eff = width_ext;
      end
      col_last = CW'(width_eff - WCW'(1));
      if (frame_height_ff < FRAME_H_W'(MIN_DIM)) begin
         row_last = FRAME_H_W'(MIN_DIM - 1);
      end else begin
         row_last = frame_height_ff - FRAME_H_W'(1);
      end
   end

   // position of the incoming pixel and whether it completes a window
   assign req_xfer  = req_valid && req_ready;
   assign emit      = (row_ff >= FRAME_H_W'(FIRST_OUT)) && (row_ff <= row_last)
                   && (col_ff >= CW'(FIRST_OUT)) && (col_ff <= col_last);
   assign emit_last = (row_ff == row_last) && (col_ff == col_last);

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (req_xfer) begin
         if (col_ff >= col_last) begin
            col_in = '0;
            row_in = (row_ff >= row_last) ? '0 : row_ff + FRAME_H_W'(1);
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // line store stage: read on transfer, write back in the cycle after
   assign req_pix.blue  = req_blue_in;
   assign req_pix.green = req_green_in;
   assign req_pix.red   = req_red_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= req_xfer;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_emit_ff <= emit;
         s1_last_ff <= emit_last;
         s1_addr_ff <= col_ff;
         s1_pix_ff  <= req_pix;
      end
   end

   assign line_wr.older = line_rd.newer;
   assign line_wr.newer = s1_pix_ff;

   c3s_ram #(
      .WIDTH ($bits(line_pair_type)),
      .DEPTH (MAX_WIDTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_addr_ff),
      .wr_data (line_wr),
      .rd_en   (req_xfer),
      .rd_addr (col_ff),
      .rd_data (line_rd)
   );

   // new column enters the rightmost cell
   assign fresh_col[ROW_TOP] = line_rd.older;
   assign fresh_col[ROW_MID] = line_rd.newer;
   assign fresh_col[ROW_BOT] = s1_pix_ff;

   // row of window column cells, leftmost is index 0
   for (genvar g = 0; g < NUM_COLS; g++) begin : g_cell
      if (g == NUM_COLS - 1) begin : g_right
         assign cell_col_in[g] = fresh_col;
      end else begin : g_inner
         assign cell_col_in[g] = cell_col_out[g+1];
      end

      assign cell_coef[g][ROW_TOP] = krow_top_ff[COEF_W*g +: COEF_W];
      assign cell_coef[g][ROW_MID] = krow_mid_ff[COEF_W*g +: COEF_W];
      assign cell_coef[g][ROW_BOT] = krow_bot_ff[COEF_W*g +: COEF_W];

      c3s_tap_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift_en (s1_valid_ff),
         .col_in   (cell_col_in[g]),
         .coef     (cell_coef[g]),
         .col_out  (cell_col_out[g]),
         .sum_out  (cell_sum[g])
      );
   end

   // track emitting pixels alongside the cell pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         win_ctl_ff  <= '0;
         prod_ctl_ff <= '0;
         col_ctl_ff  <= '0;
         tot_ctl_ff  <= '0;
      end else begin
         win_ctl_ff.valid <= s1_valid_ff && s1_emit_ff;
         win_ctl_ff.last  <= s1_last_ff;
         prod_ctl_ff      <= win_ctl_ff;
         col_ctl_ff       <= prod_ctl_ff;
         tot_ctl_ff       <= col_ctl_ff;
      end
   end

   // add the three column sums per channel
   always_comb begin
      for (int ch = 0; ch < NUM_CHANS; ch++) begin
         tot_in[ch] = SUM_W'($signed(cell_sum[0][ch]))
                    + SUM_W'($signed(cell_sum[1][ch]))
                    + SUM_W'($signed(cell_sum[2][ch]));
      end
   end

   always_ff @(posedge clock) begin
      tot_ff <= tot_in;
   end

   // floor, clamp and queue the result
   assign push_data.blue  = sat_pixel(tot_ff[0]);
   assign push_data.green = sat_pixel(tot_ff[1]);
   assign push_data.red   = sat_pixel(tot_ff[2]);
   assign push_data.last  = tot_ctl_ff.last;

   c3s_rsp_fifo #(
      .DEPTH (RSP_DEPTH)
   ) u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .reserve   (req_xfer && emit),
      .push      (tot_ctl_ff.valid),
      .push_data (push_data),
      .pop_valid (rsp_valid),
      .pop_ready (rsp_ready),
      .pop_data  (pop_data),
      .slot_free (req_ready)
   );

   assign rsp_blue_out   = pop_data.blue;
   assign rsp_green_out  = pop_data.green;
   assign rsp_red_out    = pop_data.red;
   assign rsp_frame_last = pop_data.last;

endmodule

[rtl/core/c3s_checker.sv]
// ----------------------------------------------------------------------------
// c3s_checker: port-level checks of the 3x3 RGB convolution unit
// Watches the top-level ports only; attached to the top level by bind.
// ----------------------------------------------------------------------------
module c3s_checker import c3s_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [PIX_W-1:0]       rsp_blue_out,
   input logic [PIX_W-1:0]       rsp_green_out,
   input logic [PIX_W-1:0]       rsp_red_out,
   input logic                   rsp_frame_last
);

   // a first result needs two rows of at least three pixels plus three more
   localparam int MIN_PIX_FIRST = MIN_DIM * FIRST_OUT + MIN_DIM;
   localparam int SEEN_W        = $clog2(MIN_PIX_FIRST + 1);

   logic [SEEN_W-1:0] seen_ff;
   logic              req_xfer;

   assign req_xfer = req_valid && req_ready;

   // count input transfers since reset, saturating
   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= '0;
      end else if (req_xfer && (seen_ff < SEEN_W'(MIN_PIX_FIRST))) begin
         seen_ff <= seen_ff + SEEN_W'(1);
      end
   end

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_blue_out)
         && $stable(rsp_green_out) && $stable(rsp_red_out) && $stable(rsp_frame_last))
      else $error("result changed while stalled");

   // reset empties the result queue
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result pending after reset");

   // reset leaves the input open
   a_reset_ready: assert property (@(posedge clock) reset |=> req_ready)
      else $error("input not ready after reset");

   // no result before a full window can have been seen
   a_first_window: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> seen_ff >= SEEN_W'(MIN_PIX_FIRST))
      else $error("result before a full window was transferred");

endmodule

bind conv3x3_rgb_saturating_unit c3s_checker u_c3s_checker (.*);

[tb/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the 3x3 RGB convolution unit
// Streams raster frames through the unit and checks every filtered pixel
// against a cycle-free model of the line stores, the window and the
// saturating kernel sum. Short hand-checked frames come first, then random
// frames over random geometry and kernels, and a very tall frame cut short
// by a height change.
// ----------------------------------------------------------------------------
module testbench;
   import c3s_pkg::*;

   localparam int MAX_W         = 2048;
   localparam int DRAIN_CYCLES  = 12;
   localparam int RANDOM_TARGET = 1000;
   localparam int REPORT_LIMIT  = 10;

   typedef enum logic {STEP_PIXEL, STEP_WRITE} step_kind_type;
   typedef enum int {RX_ALWAYS, RX_SPARSE, RX_PATTERN} rx_mode_type;

   // one row of the hand-written stimulus plan
   typedef struct packed {
      step_kind_type         kind;
      csr_index_type         index;
      logic [CSR_DATA_W-1:0] wdata;
      rgb_type               pixel;
      logic                  checked;
      rsp_type               result;
   } plan_step_type;

   localparam rsp_type NO_RESULT = '0;
   localparam int PLAN_ROWS = 25;

   // Frame one runs on the reset kernel (identity), so the only result is the
   // centre pixel. Frame two uses out-of-range geometry (read as 3x3), the most
   // negative top row, the most positive middle row and a half-weight bottom
   // centre: blue goes negative and clamps to zero, red saturates, green floors.
   localparam plan_step_type DIRECTED_PLAN [PLAN_ROWS] = '{
      '{STEP_WRITE, CSR_FRAME_WIDTH,  48'd3, 24'h000000, 1'b0, NO_RESULT},
      '{STEP_WRITE, CSR_FRAME_HEIGHT, 48'd3, 24'h000000, 1'b0, NO_RESULT},
      '{STEP_PIXEL, CSR_FRAME_WIDTH,  48'd0, 24'h000000, 1'b0, NO_RESULT},
      '{STEP_PIXEL, CSR_FRAME_WIDTH,  48'd0, 24'hFFFFFF, 1'b0, NO_RESULT},
      '{STEP_PIXEL, CSR_FRAME_WIDTH,  48'd0, 24'h010203, 1'b0, NO_RESULT},
      '{STEP_PIXEL, CSR_FRAME_WIDTH,  48'd0, 24'h808080, 1'b0, NO_RESULT},
      '{STEP_PIXEL, CSR_FRAME_WIDTH,  48'd0, 24'hC35A17, 1'b0, NO_RESULT},
      '{STEP_PIXEL, CSR_FRAME_WIDTH,  48'd0, 24'h7F7F7F, 1'b0, NO_RESULT},
      '{STEP_PIXEL, CSR_FRAME_WIDTH,  48'd0, 24'hFF0000, 1'b0, NO_RESULT},
      '{STEP_PIXEL, CSR_FRAME_WIDTH,  48'd0, 24'h00FF00, 1'b0, NO_RESULT},
      '{STEP_PIXEL, CSR_FRAME_WIDTH,  48'd0, 24'h0000FF, 1'b1,
        {8'h17, 8'h5A, 8'hC3, 1'b1}},
      '{STEP_WRITE, CSR_FRAME_WIDTH,  48'd0, 24'h000000, 1'b0, NO_RESULT},
      '{STEP_WRITE, CSR_FRAME_HEIGHT, 48'd0, 24'h000000, 1'b0, NO_RESULT},
      '{STEP_WRITE, CSR_KROW_TOP,     48'h8000_8000_8000, 24'h0, 1'b0, NO_RESULT},
      '{STEP_WRITE, CSR_KROW_MID,     48'h7FFF_7FFF_7FFF, 24'h0, 1'b0, NO_RESULT},
      '{STEP_WRITE, CSR_KROW_BOTTOM,  48'h0000_0080_0000, 24'h0, 1'b0, NO_RESULT},
      '{STEP_PIXEL, CSR_FRAME_WIDTH,  48'd0, 24'h0000FF, 1'b0, NO_RESULT},
      '{STEP_PIXEL, CSR_FRAME_WIDTH,  48'd0, 24'h0000FF, 1'b0, NO_RESULT},
      '{STEP_PIXEL, CSR_FRAME_WIDTH,  48'd0, 24'h0000FF, 1'b0, NO_RESULT},
      '{STEP_PIXEL, CSR_FRAME_WIDTH,  48'd0, 24'hFF0000, 1'b0, NO_RESULT},
      '{STEP_PIXEL, CSR_FRAME_WIDTH,  48'd0, 24'hFF0000, 1'b0, NO_RESULT},
      '{STEP_PIXEL, CSR_FRAME_WIDTH,  48'd0, 24'hFF0000, 1'b0, NO_RESULT},
      '{STEP_PIXEL, CSR_FRAME_WIDTH,  48'd0, 24'h00FF00, 1'b0, NO_RESULT},
      '{STEP_PIXEL, CSR_FRAME_WIDTH,  48'd0, 24'h00FF00, 1'b0, NO_RESULT},
      '{STEP_PIXEL, CSR_FRAME_WIDTH,  48'd0, 24'h00FF00, 1'b1,
        {8'h00, 8'h7F, 8'hFF, 1'b1}}
   };

   // block ports
   logic                  clock          = 1'b0;
   logic                  reset          = 1'b1;
   logic                  req_valid      = 1'b0;
   logic                  req_ready;
   logic [PIX_W-1:0]      req_blue_in    = '0;
   logic [PIX_W-1:0]      req_green_in   = '0;
   logic [PIX_W-1:0]      req_red_in     = '0;
   logic                  rsp_valid;
   logic                  rsp_ready      = 1'b0;
   logic [PIX_W-1:0]      rsp_blue_out;
   logic [PIX_W-1:0]      rsp_green_out;
   logic [PIX_W-1:0]      rsp_red_out;
   logic                  rsp_frame_last;
   logic                  csr_wr_en      = 1'b0;
   csr_index_type         csr_index      = CSR_FRAME_WIDTH;
   logic [CSR_DATA_W-1:0] csr_wdata      = '0;

   // model of the unit: settings, line stores, window and raster position
   logic [FRAME_W_W-1:0] cfg_width;
   logic [FRAME_H_W-1:0] cfg_height;
   logic [KROW_W-1:0]    cfg_krow [NUM_ROWS];
   rgb_type              row_above     [MAX_W];
   rgb_type              row_two_above [MAX_W];
   rgb_type              taps [NUM_ROWS][NUM_COLS];
   int unsigned          col_pos;
   int unsigned          row_pos;

   // filtered pixels still owed by the unit, oldest first
   rsp_type due_filtered [$];

   int pixels_sent   = 0;
   int results_seen  = 0;
   int frames_closed = 0;
   int csr_writes    = 0;
   int mismatches    = 0;
   int burst_left    = 0;

   conv3x3_rgb_saturating_unit #(.MAX_WIDTH(MAX_W)) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_blue_in    (req_blue_in),
      .req_green_in   (req_green_in),
      .req_red_in     (req_red_in),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_blue_out   (rsp_blue_out),
      .rsp_green_out  (rsp_green_out),
      .rsp_red_out    (rsp_red_out),
      .rsp_frame_last (rsp_frame_last),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      #4_000_000;
      $display("Run stopped on timeout with %0d results outstanding", due_filtered.size());
      $display("Mismatches found");
      $finish;
   end

   // Floored, clamped kernel sum of one channel over the current window.
   function automatic logic [PIX_W-1:0] filter_channel(input int chan);
      int                       acc;
      logic [PIX_W-1:0]         tap;
      logic signed [COEF_W-1:0] coef;
      acc = 0;
      for (int y = 0; y < NUM_ROWS; y++) begin
         for (int x = 0; x < NUM_COLS; x++) begin
            tap  = taps[y][x][PIX_W*chan +: PIX_W];
            coef = cfg_krow[y][COEF_W*x +: COEF_W];
            acc += int'(tap) * int'(coef);
         end
      end
      if (acc < 0) return '0;
      acc = acc >>> COEF_FRAC_BITS;
      return (acc > 255) ? 8'hFF : acc[PIX_W-1:0];
   endfunction

   // Advance the model by one pixel; returns 1 when a filtered pixel is due.
   function automatic bit convolve_pixel(input rgb_type px, output rsp_type res);
      int unsigned w;
      int unsigned h;
      int unsigned c;
      int unsigned r;
      rgb_type     up1;
      rgb_type     up2;
      bit          emits;
      w = cfg_width;
      h = cfg_height;
      if (w < MIN_DIM) w = MIN_DIM;
      if (w > MAX_W) w = MAX_W;
      if (h < MIN_DIM) h = MIN_DIM;
      c = (col_pos >= MAX_W) ? MAX_W - 1 : col_pos;
      r = row_pos;

      // rotate the line stores at this column
      up1 = row_above[c];
      up2 = row_two_above[c];
      row_two_above[c] = up1;
      row_above[c]     = px;

      // shift the window left and load the new column
      for (int y = 0; y < NUM_ROWS; y++) begin
         taps[y][0] = taps[y][1];
         taps[y][1] = taps[y][2];
      end
      taps[ROW_TOP][2] = up2;
      taps[ROW_MID][2] = up1;
      taps[ROW_BOT][2] = px;

      emits = (r >= FIRST_OUT && r <= h - 1 && c >= FIRST_OUT && c <= w - 1);
      res.blue  = filter_channel(0);
      res.green = filter_channel(1);
      res.red   = filter_channel(2);
      res.last  = (r == h - 1 && c == w - 1);

      // wrap the raster position
      if (c >= w - 1) begin
         col_pos = 0;
         row_pos = (r >= h - 1) ? 0 : r + 1;
      end else begin
         col_pos = c + 1;
      end
      return emits;
   endfunction

   function automatic rgb_type rand_pixel();
      rgb_type px;
      px = 24'($urandom);
      for (int ch = 0; ch < NUM_CHANS; ch++) begin
         case ($urandom_range(0, 7))
            0: px[PIX_W*ch +: PIX_W] = 8'h00;
            1: px[PIX_W*ch +: PIX_W] = 8'hFF;
            default: ;
         endcase
      end
      return px;
   endfunction

   function automatic void note_mismatch(input string what);
      mismatches++;
      if (mismatches <= REPORT_LIMIT) $display("%0t ns: %s", $time, what);
   endfunction

   // Offer one pixel in bursts with random gaps; log what it is owed on transfer.
   task automatic push_pixel(input rgb_type px, input logic fixed, input rsp_type fixed_res);
      rsp_type res;
      int      gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 200)
                                                  : $urandom_range(1, 30);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_valid    <= 1'b1;
      req_blue_in  <= px.blue;
      req_green_in <= px.green;
      req_red_in   <= px.red;
      do @(posedge clock); while (!req_ready);
      burst_left--;
      pixels_sent++;
      if (convolve_pixel(px, res)) due_filtered.push_back(fixed ? fixed_res : res);
   endtask

   // Hold the sender until every owed result has come and the pipe is empty.
   task automatic settle();
      req_valid <= 1'b0;
      burst_left = 0;
      while (due_filtered.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // One register write; the caller drops the enable after the last of a group.
   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         CSR_FRAME_WIDTH:  cfg_width  = data[FRAME_W_W-1:0];
         CSR_FRAME_HEIGHT: cfg_height = data[FRAME_H_W-1:0];
         CSR_KROW_TOP:     cfg_krow[ROW_TOP] = data;
         CSR_KROW_MID:     cfg_krow[ROW_MID] = data;
         CSR_KROW_BOTTOM:  cfg_krow[ROW_BOT] = data;
         default: ;
      endcase
      csr_writes++;
   endtask

   // Run whole frames: stop each time the raster position returns to the origin.
   task automatic feed_frames(input int count);
      repeat (count) begin
         do push_pixel(rand_pixel(), 1'b0, NO_RESULT);
         while (col_pos != 0 || row_pos != 0);
      end
   endtask

   // Receiver: stall in modes of random length.
   initial begin
      rx_mode_type mode;
      int          span;
      logic [15:0] pattern;
      forever begin
         mode    = rx_mode_type'($urandom_range(0, 2));
         span    = $urandom_range(32, 256);
         pattern = 16'($urandom) | 16'h0001;
         for (int i = 0; i < span; i++) begin
            @(posedge clock);
            case (mode)
               RX_ALWAYS: rsp_ready <= 1'b1;
               RX_SPARSE: rsp_ready <= ($urandom_range(0, 3) == 0);
               default:   rsp_ready <= pattern[i % 16];
            endcase
         end
      end
   end

   // Compare each result transfer with the oldest owed pixel.
   always @(posedge clock) begin : result_check
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (rsp_frame_last) frames_closed++;
         if (due_filtered.size() == 0) begin
            note_mismatch($sformatf("unexpected result b=%h g=%h r=%h last=%b",
                          rsp_blue_out, rsp_green_out, rsp_red_out, rsp_frame_last));
         end else begin
            want = due_filtered.pop_front();
            if (rsp_blue_out !== want.blue || rsp_green_out !== want.green ||
                rsp_red_out !== want.red || rsp_frame_last !== want.last) begin
               note_mismatch($sformatf(
                  "result %0d: want b=%h g=%h r=%h last=%b, got b=%h g=%h r=%h last=%b",
                  results_seen, want.blue, want.green, want.red, want.last,
                  rsp_blue_out, rsp_green_out, rsp_red_out, rsp_frame_last));
            end
         end
      end
   end

   initial begin : stimulus
      logic                  writing;
      int                    random_start;
      logic [CSR_DATA_W-1:0] wdata;
      logic [KROW_W-1:0]     krow;
      bit                    first_phase;

      // model starts from the reset settings
      cfg_width  = FRAME_W_RESET;
      cfg_height = FRAME_H_RESET;
      cfg_krow[ROW_TOP] = KROW_TOP_RESET;
      cfg_krow[ROW_MID] = KROW_MID_RESET;
      cfg_krow[ROW_BOT] = KROW_BOT_RESET;
      for (int i = 0; i < MAX_W; i++) begin
         row_above[i]     = '0;
         row_two_above[i] = '0;
      end
      for (int y = 0; y < NUM_ROWS; y++) begin
         for (int x = 0; x < NUM_COLS; x++) taps[y][x] = '0;
      end
      col_pos = 0;
      row_pos = 0;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // walk the hand-written plan
      writing = 1'b0;
      for (int i = 0; i < PLAN_ROWS; i++) begin
         if (DIRECTED_PLAN[i].kind == STEP_WRITE) begin
            if (!writing) settle();
            writing = 1'b1;
            write_reg(DIRECTED_PLAN[i].index, DIRECTED_PLAN[i].wdata);
         end else begin
            if (writing) csr_wr_en <= 1'b0;
            writing = 1'b0;
            push_pixel(DIRECTED_PLAN[i].pixel, DIRECTED_PLAN[i].checked,
                       DIRECTED_PLAN[i].result);
         end
      end

      // random phases: new settings between whole frames
      random_start = pixels_sent;
      first_phase  = 1'b1;
      while (pixels_sent - random_start < RANDOM_TARGET) begin
         settle();
         if (first_phase || $urandom_range(0, 3) != 0) begin
            wdata = {16'($urandom), 32'($urandom)};
            case ($urandom_range(0, 9))
               0:       wdata[FRAME_W_W-1:0] = 12'($urandom_range(0, 2));
               1:       wdata[FRAME_W_W-1:0] = 12'($urandom_range(13, 40));
               default: wdata[FRAME_W_W-1:0] = 12'($urandom_range(3, 12));
            endcase
            write_reg(CSR_FRAME_WIDTH, wdata);
            wdata = {16'($urandom), 32'($urandom)};
            wdata[FRAME_H_W-1:0] = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 2))
                                                               : 16'($urandom_range(3, 8));
            write_reg(CSR_FRAME_HEIGHT, wdata);
         end
         for (int k = 0; k < NUM_ROWS; k++) begin
            if (first_phase || $urandom_range(0, 1) == 0) begin
               case ($urandom_range(0, 5))
                  0: krow = '0;
                  1: krow = '1;
                  2: krow = {16'($urandom), 32'($urandom)};
                  default: begin
                     for (int x = 0; x < NUM_COLS; x++) begin
                        krow[COEF_W*x +: COEF_W] = 16'($urandom_range(0, 512)) - 16'd192;
                     end
                  end
               endcase
               write_reg(csr_index_type'(CSR_KROW_TOP + k), krow);
            end
         end
         csr_wr_en <= 1'b0;
         first_phase = 1'b0;
         feed_frames($urandom_range(1, 3));
      end

      // tallest frame, cut short by a smaller height part-way down
      settle();
      write_reg(CSR_FRAME_WIDTH, 48'd4);
      write_reg(CSR_FRAME_HEIGHT, 48'hFFFF);
      csr_wr_en <= 1'b0;
      repeat (4 * 12) push_pixel(rand_pixel(), 1'b0, NO_RESULT);
      settle();
      write_reg(CSR_FRAME_HEIGHT, 48'($urandom_range(3, 6)));
      csr_wr_en <= 1'b0;
      feed_frames(2);

      settle();
      $display("Sent %0d pixels and compared %0d filtered pixels over %0d frames",
               pixels_sent, results_seen, frames_closed);
      $display("Made %0d register writes: rows of 3 to 40 pixels, heights up to 65535",
               csr_writes);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
